@@ hdl/e2q_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// constants, tables and types shared by the euler to quaternion block
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int DEF_COMPONENT_BITS    = 16;
  localparam int DEF_SINCOS_ITERATIONS = 16;

  localparam int ANGLE_W     = 16;
  localparam int ANGLE_LIMIT = 23040;
  localparam int MAG_W       = 15;
  localparam int RP_W        = 30;
  localparam int K_W         = 9;
  localparam int R_W         = 7;

  // phase = round(angle * 2^23 / 90), angle split as 90 * k + r
  localparam int DEG_DIV  = 90;
  localparam int RECIP    = 23302;
  localparam int RECIP_SH = 21;
  localparam int PH_FRAC  = 23;
  localparam int PH_W     = 32;

  localparam int CORDIC_W = 34;
  localparam int SC_W     = 32;
  localparam int PROD_W   = 64;

  localparam logic signed [CORDIC_W-1:0] ONE_Q30   = 34'sh0_4000_0000;
  localparam logic signed [CORDIC_W-1:0] HALF_TURN = 34'sh0_8000_0000;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
    30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
    30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
    30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005,
    30'h00000003, 30'h00000001, 30'h00000001, 30'h00000000
  };

  typedef logic [PH_FRAC-1:0] frac_tab_t [DEG_DIV];

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    longint    num;
    for (int i = 0; i < DEG_DIV; i++) begin
      num    = (longint'(i) <<< PH_FRAC) + longint'(DEG_DIV / 2);
      tab[i] = PH_FRAC'(num / DEG_DIV);
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage
`default_nettype wire

@@ hdl/e2q_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_in_if
// request channel: product order and three euler angles
// ----------------------------------------------------------------------------
interface e2q_in_if
  import e2q_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [ANGLE_W-1:0] angle_x;
  logic signed [ANGLE_W-1:0] angle_y;
  logic signed [ANGLE_W-1:0] angle_z;

  modport source (output valid, op, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, op, angle_x, angle_y, angle_z, output ready);
endinterface
`default_nettype wire

@@ hdl/e2q_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_out_if
// result channel: quaternion components
// ----------------------------------------------------------------------------
interface e2q_out_if
  import e2q_pkg::*;
#(
  parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] quat_x;
  logic signed [COMPONENT_BITS-1:0] quat_y;
  logic signed [COMPONENT_BITS-1:0] quat_z;
  logic signed [COMPONENT_BITS-1:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

@@ hdl/euler_to_quaternion.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Euler angles (1/64 degree, saturated to +/-360 degrees) to a Q1.15
// rotation quaternion, pitch*yaw*roll or roll*pitch*yaw. A request is taken
// every cycle unless the result side stalls. The pipeline is the CORDIC
// rotator, one register stage per iteration, plus three phase stages, a fold
// stage and four stages of the two Hamilton products.
// A stall on the result side holds the whole pipeline.
// ----------------------------------------------------------------------------
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int COMPONENT_BITS    = DEF_COMPONENT_BITS,
  parameter int SINCOS_ITERATIONS = DEF_SINCOS_ITERATIONS
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  e2q_in_if.sink     req_i,
  e2q_out_if.source  rsp_o
);

  localparam int ITER   = (SINCOS_ITERATIONS > 32) ? 32 : SINCOS_ITERATIONS;
  localparam int NV     = ITER + 8;
  localparam int CW     = CORDIC_W;
  localparam int FRAC   = COMPONENT_BITS - 1;
  localparam int SHR    = (FRAC < 30) ? 30 - FRAC : 0;
  localparam int SHL    = (FRAC > 30) ? FRAC - 30 : 0;
  localparam int OW     = 38;
  localparam longint RND = (SHR > 0) ? (64'sd1 <<< ((SHR > 0) ? SHR - 1 : 0)) : 0;
  localparam logic signed [OW-1:0] OMAX = OW'((64'sd1 <<< FRAC) - 64'sd1);
  localparam logic signed [OW-1:0] OMIN = -OMAX - OW'(1);

  logic          en;
  logic [NV-1:0] vld_q;

  assign en          = !vld_q[NV-1] || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], req_i.valid};
    end
  end

  // stage 1: saturate, negate yaw, reciprocal multiply
  logic                      s1_op_q;
  logic                      s1_neg_q [3];
  logic [MAG_W-1:0]          s1_mag_q [3];
  logic [RP_W-1:0]           s1_rp_q  [3];
  logic signed [ANGLE_W-1:0] ang      [3];
  logic signed [ANGLE_W-1:0] sat      [3];
  logic                      s1_neg_d [3];
  logic [MAG_W-1:0]          s1_mag_d [3];

  assign ang[0] = req_i.angle_x;
  assign ang[1] = req_i.angle_y;
  assign ang[2] = req_i.angle_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (ang[j] > ANGLE_W'(ANGLE_LIMIT)) begin
        sat[j] = ANGLE_W'(ANGLE_LIMIT);
      end else if (ang[j] < -ANGLE_W'(ANGLE_LIMIT)) begin
        sat[j] = -ANGLE_W'(ANGLE_LIMIT);
      end else begin
        sat[j] = ang[j];
      end
      if (j == 1) begin
        sat[j] = -sat[j];
      end
      s1_neg_d[j] = sat[j][ANGLE_W-1];
      s1_mag_d[j] = s1_neg_d[j] ? MAG_W'(-sat[j]) : MAG_W'(sat[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= req_i.op;
      for (int j = 0; j < 3; j++) begin
        s1_neg_q[j] <= s1_neg_d[j];
        s1_mag_q[j] <= s1_mag_d[j];
        s1_rp_q[j]  <= RP_W'(s1_mag_d[j]) * RP_W'(RECIP);
      end
    end
  end

  // stage 2: whole and partial multiples of 90
  logic             s2_op_q;
  logic             s2_neg_q [3];
  logic [K_W-1:0]   s2_k_q   [3];
  logic [R_W-1:0]   s2_r_q   [3];
  logic [K_W-1:0]   s2_k_d   [3];
  logic [MAG_W-1:0] s2_rem   [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s2_k_d[j] = K_W'(s1_rp_q[j] >> RECIP_SH);
      s2_rem[j] = s1_mag_q[j] - MAG_W'(s2_k_d[j]) * MAG_W'(DEG_DIV);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q <= s1_op_q;
      for (int j = 0; j < 3; j++) begin
        s2_neg_q[j] <= s1_neg_q[j];
        s2_k_q[j]   <= s2_k_d[j];
        s2_r_q[j]   <= R_W'(s2_rem[j]);
      end
    end
  end

  // stage 3: phase and fold into +/-90 degrees
  logic                   s3_op_q;
  logic                   s3_flip_q [3];
  logic signed [CW-1:0]   s3_z_q    [3];
  logic [PH_W-1:0]        ph_mag    [3];
  logic signed [PH_W:0]   ph        [3];
  logic signed [CW-1:0]   s3_z_d    [3];
  logic                   s3_flip_d [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ph_mag[j] = (PH_W'(s2_k_q[j]) << PH_FRAC) | PH_W'(FRAC_TAB[s2_r_q[j]]);
      ph[j]     = s2_neg_q[j] ? -$signed({1'b0, ph_mag[j]}) : $signed({1'b0, ph_mag[j]});
      s3_z_d[j] = CW'(ph[j]);
      s3_flip_d[j] = 1'b0;
      if (s3_z_d[j] > ONE_Q30) begin
        s3_z_d[j]    = s3_z_d[j] - HALF_TURN;
        s3_flip_d[j] = 1'b1;
      end else if (s3_z_d[j] < -ONE_Q30) begin
        s3_z_d[j]    = s3_z_d[j] + HALF_TURN;
        s3_flip_d[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_op_q <= s2_op_q;
      for (int j = 0; j < 3; j++) begin
        s3_z_q[j]    <= s3_z_d[j];
        s3_flip_q[j] <= s3_flip_d[j];
      end
    end
  end

  // cordic rotator, one iteration per stage
  logic                 c_op_q   [ITER];
  logic                 c_flip_q [ITER][3];
  logic signed [CW-1:0] c_x_q    [ITER][3];
  logic signed [CW-1:0] c_y_q    [ITER][3];
  logic signed [CW-1:0] c_z_q    [ITER][3];

  for (genvar gi = 0; gi < ITER; gi++) begin : g_cordic
    localparam logic signed [CW-1:0] ANG = $signed(CW'(ATAN_TAB[gi]));
    logic                 oi;
    logic                 fi [3];
    logic signed [CW-1:0] xi [3];
    logic signed [CW-1:0] yi [3];
    logic signed [CW-1:0] zi [3];

    if (gi == 0) begin : g_first
      always_comb begin
        oi = s3_op_q;
        for (int j = 0; j < 3; j++) begin
          fi[j] = s3_flip_q[j];
          xi[j] = CORDIC_GAIN;
          yi[j] = '0;
          zi[j] = s3_z_q[j];
        end
      end
    end else begin : g_next
      always_comb begin
        oi = c_op_q[gi-1];
        for (int j = 0; j < 3; j++) begin
          fi[j] = c_flip_q[gi-1][j];
          xi[j] = c_x_q[gi-1][j];
          yi[j] = c_y_q[gi-1][j];
          zi[j] = c_z_q[gi-1][j];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        c_op_q[gi] <= oi;
        for (int j = 0; j < 3; j++) begin
          c_flip_q[gi][j] <= fi[j];
          if (zi[j] >= 0) begin
            c_x_q[gi][j] <= xi[j] - (yi[j] >>> gi);
            c_y_q[gi][j] <= yi[j] + (xi[j] >>> gi);
            c_z_q[gi][j] <= zi[j] - ANG;
          end else begin
            c_x_q[gi][j] <= xi[j] + (yi[j] >>> gi);
            c_y_q[gi][j] <= yi[j] - (xi[j] >>> gi);
            c_z_q[gi][j] <= zi[j] + ANG;
          end
        end
      end
    end
  end

  // undo the fold and clamp sine and cosine
  logic                   cl_op_q;
  logic signed [SC_W-1:0] cl_s_q [3];
  logic signed [SC_W-1:0] cl_c_q [3];
  logic signed [CW-1:0]   fx     [3];
  logic signed [CW-1:0]   fy     [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fx[j] = c_flip_q[ITER-1][j] ? -c_x_q[ITER-1][j] : c_x_q[ITER-1][j];
      fy[j] = c_flip_q[ITER-1][j] ? -c_y_q[ITER-1][j] : c_y_q[ITER-1][j];
      if (fx[j] > ONE_Q30) begin
        fx[j] = ONE_Q30;
      end else if (fx[j] < -ONE_Q30) begin
        fx[j] = -ONE_Q30;
      end
      if (fy[j] > ONE_Q30) begin
        fy[j] = ONE_Q30;
      end else if (fy[j] < -ONE_Q30) begin
        fy[j] = -ONE_Q30;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_op_q <= c_op_q[ITER-1];
      for (int j = 0; j < 3; j++) begin
        cl_c_q[j] <= SC_W'(fx[j]);
        cl_s_q[j] <= SC_W'(fy[j]);
      end
    end
  end

  // first hamilton product: both operands are single-axis
  logic                     m1_op_q;
  logic signed [PROD_W-1:0] m1_p_q [4];
  logic signed [SC_W-1:0]   m1_s_q;
  logic signed [SC_W-1:0]   m1_c_q;
  logic signed [SC_W-1:0]   as, ac, bs, bc;
  logic signed [SC_W-1:0]   f1 [4];
  logic signed [SC_W-1:0]   f2 [4];

  always_comb begin
    if (cl_op_q) begin
      as = cl_s_q[2]; ac = cl_c_q[2];
      bs = cl_s_q[0]; bc = cl_c_q[0];
      f1[0] = ac; f2[0] = bs;
      f1[1] = as; f2[1] = bs;
      f1[2] = as; f2[2] = bc;
    end else begin
      as = cl_s_q[0]; ac = cl_c_q[0];
      bs = cl_s_q[1]; bc = cl_c_q[1];
      f1[0] = as; f2[0] = bc;
      f1[1] = ac; f2[1] = bs;
      f1[2] = as; f2[2] = bs;
    end
    f1[3] = ac; f2[3] = bc;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_op_q <= cl_op_q;
      m1_s_q  <= cl_op_q ? cl_s_q[1] : cl_s_q[2];
      m1_c_q  <= cl_op_q ? cl_c_q[1] : cl_c_q[2];
      for (int k = 0; k < 4; k++) begin
        m1_p_q[k] <= f1[k] * f2[k];
      end
    end
  end

  // round the intermediate quaternion
  logic                     r1_op_q;
  logic signed [SC_W-1:0]   r1_t_q [4];
  logic signed [SC_W-1:0]   r1_s_q;
  logic signed [SC_W-1:0]   r1_c_q;
  logic signed [PROD_W-1:0] r1_rs  [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r1_rs[k] = m1_p_q[k] + 64'sd536870912;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_op_q <= m1_op_q;
      r1_s_q  <= m1_s_q;
      r1_c_q  <= m1_c_q;
      for (int k = 0; k < 4; k++) begin
        r1_t_q[k] <= r1_rs[k][61:30];
      end
    end
  end

  // second hamilton product with the remaining single-axis quaternion
  logic                     m2_neg_q [4];
  logic signed [PROD_W-1:0] m2_pc_q  [4];
  logic signed [PROD_W-1:0] m2_ps_q  [4];
  logic signed [SC_W-1:0]   pt       [4];
  logic                     m2_neg_d [4];

  always_comb begin
    if (r1_op_q) begin
      pt[0] = r1_t_q[2]; m2_neg_d[0] = 1'b1;
      pt[1] = r1_t_q[3]; m2_neg_d[1] = 1'b0;
      pt[2] = r1_t_q[0]; m2_neg_d[2] = 1'b0;
      pt[3] = r1_t_q[1]; m2_neg_d[3] = 1'b1;
    end else begin
      pt[0] = r1_t_q[1]; m2_neg_d[0] = 1'b0;
      pt[1] = r1_t_q[0]; m2_neg_d[1] = 1'b1;
      pt[2] = r1_t_q[3]; m2_neg_d[2] = 1'b0;
      pt[3] = r1_t_q[2]; m2_neg_d[3] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        m2_neg_q[k] <= m2_neg_d[k];
        m2_pc_q[k]  <= r1_t_q[k] * r1_c_q;
        m2_ps_q[k]  <= pt[k] * r1_s_q;
      end
    end
  end

  // sum, round and saturate to the output format
  logic signed [COMPONENT_BITS-1:0] out_q [4];
  logic signed [PROD_W:0]           sm    [4];
  logic signed [PROD_W-30:0]        rv    [4];
  logic signed [OW-1:0]             ov    [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sm[k] = m2_neg_q[k] ? (PROD_W+1)'(m2_pc_q[k]) - (PROD_W+1)'(m2_ps_q[k])
                          : (PROD_W+1)'(m2_pc_q[k]) + (PROD_W+1)'(m2_ps_q[k]);
      sm[k] = sm[k] + 65'sd536870912;
      rv[k] = sm[k][PROD_W:30];
      ov[k] = ((OW'(rv[k]) + OW'(RND)) >>> SHR) <<< SHL;
      if (ov[k] > OMAX) begin
        ov[k] = OMAX;
      end else if (ov[k] < OMIN) begin
        ov[k] = OMIN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        out_q[k] <= COMPONENT_BITS'(ov[k]);
      end
    end
  end

  assign rsp_o.quat_x = out_q[0];
  assign rsp_o.quat_y = out_q[1];
  assign rsp_o.quat_z = out_q[2];
  assign rsp_o.quat_w = out_q[3];

  // folded phase stays within a quarter turn
  a_phase_folded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (s3_z_q[0] <= ONE_Q30 && s3_z_q[0] >= -ONE_Q30 &&
                  s3_z_q[1] <= ONE_Q30 && s3_z_q[1] >= -ONE_Q30 &&
                  s3_z_q[2] <= ONE_Q30 && s3_z_q[2] >= -ONE_Q30))
    else $error("phase fold out of range");

  // reciprocal split leaves a remainder below 90
  a_split_exact : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (s2_r_q[0] < R_W'(DEG_DIV) && s2_r_q[1] < R_W'(DEG_DIV) &&
                  s2_r_q[2] < R_W'(DEG_DIV)))
    else $error("angle split remainder out of range");

  // a stalled pipeline keeps its occupancy
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline occupancy changed during stall");

endmodule
`default_nettype wire

@@ tb/sv/euler_to_quaternion_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_checker
// watches the request and result channels, computes the expected quaternion
// of every accepted request and compares it with the results in order
// ----------------------------------------------------------------------------
module euler_to_quaternion_checker
  import e2q_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  e2q_in_if.sink     req_mon,
  e2q_out_if.sink    rsp_mon,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_o
);

  typedef struct {
    longint x;
    longint y;
    longint z;
    longint w;
  } quat_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] w;
  } quat_code_t;

  quat_code_t expected_quats[$];
  int         fail_count = 0;
  int         results    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_quats.size();
  assign results_o    = results;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // cosine and sine of half the angle, 30 fraction bits
  function automatic void half_angle_trig(longint a, output longint s, output longint c);
    longint num, ph, x, y, nx;
    longint one;
    bit     flip;
    one  = longint'(1) <<< 30;
    num  = a * (longint'(1) <<< 23);
    ph   = num >= 0 ? (num + 45) / 90 : -((-num + 45) / 90);
    flip = 0;
    x    = 652032874;
    y    = 0;
    if (ph > one) begin
      ph -= 2 * one;
      flip = 1;
    end else if (ph < -one) begin
      ph += 2 * one;
      flip = 1;
    end
    for (int i = 0; i < DEF_SINCOS_ITERATIONS && i < 32; i++) begin
      if (ph >= 0) begin
        nx = x - asr(y, i);
        y  = y + asr(x, i);
        ph -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + asr(y, i);
        y  = y - asr(x, i);
        ph += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(x, -one, one);
    s = clip(y, -one, one);
  endfunction

  function automatic longint round30(longint v);
    return asr(v + (longint'(1) <<< 29), 30);
  endfunction

  function automatic quat_t hamilton(quat_t a, quat_t b);
    quat_t r;
    r.x = round30(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
    r.y = round30(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x);
    r.z = round30(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w);
    r.w = round30(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
    return r;
  endfunction

  function automatic logic signed [15:0] to_q15(longint v);
    v = asr(v + (longint'(1) <<< 14), 15);
    v = clip(v, -32768, 32767);
    return 16'(v);
  endfunction

  function automatic quat_code_t euler_quat(logic op, logic signed [15:0] ax,
                                            logic signed [15:0] ay,
                                            logic signed [15:0] az);
    quat_t      p, yw, rl, r;
    quat_code_t q;
    p  = '{0, 0, 0, 0};
    yw = '{0, 0, 0, 0};
    rl = '{0, 0, 0, 0};
    half_angle_trig(clip(longint'(ax), -ANGLE_LIMIT, ANGLE_LIMIT), p.x, p.w);
    half_angle_trig(-clip(longint'(ay), -ANGLE_LIMIT, ANGLE_LIMIT), yw.y, yw.w);
    half_angle_trig(clip(longint'(az), -ANGLE_LIMIT, ANGLE_LIMIT), rl.z, rl.w);
    if (op) r = hamilton(hamilton(rl, p), yw);
    else    r = hamilton(hamilton(p, yw), rl);
    q.x = to_q15(r.x);
    q.y = to_q15(r.y);
    q.z = to_q15(r.z);
    q.w = to_q15(r.w);
    return q;
  endfunction

  always @(posedge clk_i) begin
    quat_code_t e;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready)
        expected_quats.push_back(euler_quat(req_mon.op, req_mon.angle_x,
                                            req_mon.angle_y, req_mon.angle_z));
      if (rsp_mon.valid && rsp_mon.ready) begin
        results++;
        if (expected_quats.size() == 0) begin
          $error("unexpected result");
          fail_count++;
        end else begin
          e = expected_quats.pop_front();
          if (rsp_mon.quat_x !== e.x) begin
            $error("quat_x expected %0d actual %0d", e.x, rsp_mon.quat_x);
            fail_count++;
          end
          if (rsp_mon.quat_y !== e.y) begin
            $error("quat_y expected %0d actual %0d", e.y, rsp_mon.quat_y);
            fail_count++;
          end
          if (rsp_mon.quat_z !== e.z) begin
            $error("quat_z expected %0d actual %0d", e.z, rsp_mon.quat_z);
            fail_count++;
          end
          if (rsp_mon.quat_w !== e.w) begin
            $error("quat_w expected %0d actual %0d", e.w, rsp_mon.quat_w);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/euler_to_quaternion_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb
// drives directed and random euler angle requests with random gaps and
// result stalls; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb;
  import e2q_pkg::*;

  localparam int N_RANDOM  = 400;
  localparam int IDLE_MAX  = 17;
  localparam int WDOG_MAX  = 2000;
  localparam int DRAIN_CYC = 60;

  logic clk_i  = 0;
  logic rst_ni = 0;

  e2q_in_if  req_if ();
  e2q_out_if rsp_if ();

  int fail_count, pending, results;
  int sent     = 0;
  int idle_cyc = 0;
  bit stall_on = 1;

  euler_to_quaternion u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  euler_to_quaternion_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    req_if.valid   = 0;
    req_if.op      = 0;
    req_if.angle_x = 0;
    req_if.angle_y = 0;
    req_if.angle_z = 0;
    rsp_if.ready   = 0;
  end

  // result side stalls
  initial begin
    int w;
    @(posedge clk_i iff rst_ni);
    forever begin
      w = stall_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (w > 0) begin
        rsp_if.ready <= 0;
        repeat (w) @(posedge clk_i);
      end
      rsp_if.ready <= 1;
      @(posedge clk_i iff (rsp_if.ready && rsp_if.valid));
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cyc <= 0;
    else if (rst_ni) begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WDOG_MAX) begin
        $display("euler_to_quaternion_tb failed");
        $finish;
      end
    end
  end

  task automatic send_request(logic op, logic signed [15:0] ax,
                              logic signed [15:0] ay, logic signed [15:0] az,
                              int gap);
    if (gap > 0) begin
      req_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1;
    req_if.op      <= op;
    req_if.angle_x <= ax;
    req_if.angle_y <= ay;
    req_if.angle_z <= az;
    @(posedge clk_i iff req_if.ready);
    sent++;
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(23030, 23050)) * ($urandom_range(0, 1) ? 1 : -1);
      2:       return 16'($urandom_range(0, 8)) * 16'sd5760;
      default: return 16'($signed($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  initial begin
    logic signed [15:0] corner [10];
    int k;
    corner = '{16'sh7FFF, -16'sh8000, 16'sd23040, -16'sd23040, 16'sd23041,
               -16'sd23041, 0, 16'sd5760, -16'sd11520, 16'sh5555};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, saturation, both product orders
    for (int i = 0; i < 10; i++)
      send_request(i[0], corner[i], corner[(i + 3) % 10], corner[(i + 7) % 10], 0);
    send_request(0, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 0);
    send_request(1, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 0);
    send_request(0, 16'sd64, -16'sd64, 16'sd1, 1);
    send_request(1, 16'sd64, -16'sd64, 16'sd1, 0);

    // hold off until every pending result is back
    req_if.valid <= 0;
    @(posedge clk_i iff pending == 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 150) stall_on = 0;
      if (n == 200) stall_on = 1;
      k = (n >= 250 && n < 300) ? 0 : $urandom_range(0, IDLE_MAX);
      if ($urandom_range(0, 2) == 0 && k > 0) k = 0;
      send_request($urandom_range(0, 1), rand_angle(), rand_angle(), rand_angle(), k);
    end
    req_if.valid <= 0;

    @(posedge clk_i iff pending == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked", sent, results);
    $display("covered both product orders, angle saturation and random stalls");
    if (fail_count == 0 && pending == 0)
      $display("euler_to_quaternion_tb passed");
    else
      $display("euler_to_quaternion_tb failed");
    $finish;
  end

endmodule
